// File: design/irqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irqc_pkg
// Shared constants, control-word layout and microcode table of the
// interrupt request controller.
// ----------------------------------------------------------------------------
package irqc_pkg;

    // pin set and field widths
    localparam int PinCount  = 8;
    localparam int PinW      = $clog2(PinCount);
    localparam int VectorW   = 8;
    localparam int CmdW      = 2;
    localparam int CfgIndexW = 2;
    localparam int CfgDataW  = 8;
    localparam int StepW     = 3;
    localparam logic [VectorW-1:0] VectorBaseReset = 8'd32;

    // command codes
    localparam logic [CmdW-1:0] CmdRaise  = 2'd0;
    localparam logic [CmdW-1:0] CmdClear  = 2'd1;
    localparam logic [CmdW-1:0] CmdEoi    = 2'd2;
    localparam logic [CmdW-1:0] CmdUnused = 2'd3;

    // configuration register indexes
    localparam logic [CfgIndexW-1:0] RegIrqMask    = 2'd0;
    localparam logic [CfgIndexW-1:0] RegAutoEoi    = 2'd1;
    localparam logic [CfgIndexW-1:0] RegVectorBase = 2'd2;

    // datapath actions
    localparam logic [2:0] ActNone    = 3'd0;
    localparam logic [2:0] ActLatch   = 3'd1;
    localparam logic [2:0] ActUpdate  = 3'd2;
    localparam logic [2:0] ActVisit   = 3'd3;
    localparam logic [2:0] ActClrIns  = 3'd4;

    // jump conditions
    localparam logic [2:0] CondNever    = 3'd0;
    localparam logic [2:0] CondAlways   = 3'd1;
    localparam logic [2:0] CondNoItem   = 3'd2;
    localparam logic [2:0] CondSkip     = 3'd3;
    localparam logic [2:0] CondEoi      = 3'd4;
    localparam logic [2:0] CondNoCpu    = 3'd5;
    localparam logic [2:0] CondScanMore = 3'd6;

    // program addresses
    localparam logic [StepW-1:0] StepFetch  = 3'd0;
    localparam logic [StepW-1:0] StepDecode = 3'd1;
    localparam logic [StepW-1:0] StepKind   = 3'd2;
    localparam logic [StepW-1:0] StepUpdate = 3'd3;
    localparam logic [StepW-1:0] StepScan   = 3'd4;
    localparam logic [StepW-1:0] StepDone   = 3'd5;
    localparam logic [StepW-1:0] StepEoi    = 3'd6;
    localparam logic [StepW-1:0] StepSpare  = 3'd7;

    typedef struct packed {
        logic             ready;
        logic [2:0]       act;
        logic [2:0]       cond;
        logic [StepW-1:0] target;
    } ucode_t;

    // control store: one word per step
    function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
        ucode_t w;
        case (step)
            StepFetch:  w = '{1'b1, ActLatch,  CondNoItem,   StepFetch};
            StepDecode: w = '{1'b0, ActNone,   CondSkip,     StepFetch};
            StepKind:   w = '{1'b0, ActNone,   CondEoi,      StepEoi};
            StepUpdate: w = '{1'b0, ActUpdate, CondNoCpu,    StepFetch};
            StepScan:   w = '{1'b0, ActVisit,  CondScanMore, StepScan};
            StepDone:   w = '{1'b0, ActNone,   CondAlways,   StepFetch};
            StepEoi:    w = '{1'b0, ActClrIns, CondAlways,   StepFetch};
            default:    w = '{1'b0, ActNone,   CondAlways,   StepFetch};
        endcase
        return w;
    endfunction

endpackage

// File: design/interrupt_request_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_request_controller
// Interrupt controller without priorities, run by a small microcode program:
// pending and in-service bitsets, ascending scan, one transaction per
// delivered interrupt.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  s_       | in        | s_valid / s_ready   | s_cmd, s_pin_number, s_cpu_accepts
//  m_       | out       | m_valid / m_ready   | m_vector, m_source_pin, m_last
//  cfg_     | in        | cfg_wr_en           | cfg_index, cfg_wdata
//
// A raise or clear that scans: fetch, two decode steps, the pending update,
// one scan step per pin (eight), a closing step. End-of-interrupt: fetch, two
// decode steps, in-service clear; ignored: fetch, decode; refused: to update.
// The scan step waits in place while a delivered vector is still in the
// output register and the next one is due.
// Synchronous active-low reset clears both bitsets and the output valid flag and
// restores irq_mask 0, auto_eoi 0, vector_base 32.
// ----------------------------------------------------------------------------
module interrupt_request_controller (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [irqc_pkg::CmdW-1:0]      s_cmd,
    input  logic [irqc_pkg::PinW-1:0]      s_pin_number,
    input  logic                           s_cpu_accepts,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [irqc_pkg::VectorW-1:0]   m_vector,
    output logic [irqc_pkg::PinW-1:0]      m_source_pin,
    output logic                           m_last,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [irqc_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [irqc_pkg::CfgDataW-1:0]  cfg_wdata
);

    localparam int PinCount = irqc_pkg::PinCount;
    localparam int PinW     = irqc_pkg::PinW;

    // sequencer
    logic [irqc_pkg::StepW-1:0] step_reg, step_next;
    irqc_pkg::ucode_t           uw;
    logic                       jump;

    // configuration
    logic [PinCount-1:0]             irq_mask_reg;
    logic                            auto_eoi_reg;
    logic [irqc_pkg::VectorW-1:0]    vector_base_reg;

    // state and latched transaction
    logic [PinCount-1:0]        pending_reg, pending_next;
    logic [PinCount-1:0]        in_service_reg, in_service_next;
    logic [irqc_pkg::CmdW-1:0]  cmd_reg;
    logic [PinW-1:0]            pin_reg;
    logic                       accepts_reg;
    logic [PinW-1:0]            scan_pin_reg, scan_pin_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [irqc_pkg::VectorW-1:0]  vector_reg, vector_next;
    logic [PinW-1:0]               source_reg, source_next;
    logic                          last_reg, last_next;

    // scan helpers
    logic [PinCount-1:0] eligible;
    logic [PinCount-1:0] above;
    logic                hit;
    logic                stall;
    logic                in_accept;
    logic                skip_item;

    assign uw        = irqc_pkg::ucode_rom(step_reg);
    assign s_ready   = uw.ready;
    assign in_accept = s_valid && uw.ready;

    assign m_valid      = m_valid_reg;
    assign m_vector     = vector_reg;
    assign m_source_pin = source_reg;
    assign m_last       = last_reg;

    // pins that would be delivered now, and those above the scan position
    assign eligible = pending_reg & ~irq_mask_reg & ~in_service_reg;
    always_comb begin
        for (int i = 0; i < PinCount; i++) begin
            above[i] = (i > int'(scan_pin_reg));
        end
    end
    assign hit   = eligible[scan_pin_reg];
    assign stall = hit && m_valid_reg && !m_ready;

    assign skip_item = (cmd_reg == irqc_pkg::CmdUnused) ||
                       ((cmd_reg == irqc_pkg::CmdRaise) && irq_mask_reg[pin_reg]);

    // jump condition select
    always_comb begin
        case (uw.cond)
            irqc_pkg::CondNever:    jump = 1'b0;
            irqc_pkg::CondAlways:   jump = 1'b1;
            irqc_pkg::CondNoItem:   jump = !s_valid;
            irqc_pkg::CondSkip:     jump = skip_item;
            irqc_pkg::CondEoi:      jump = (cmd_reg == irqc_pkg::CmdEoi);
            irqc_pkg::CondNoCpu:    jump = !accepts_reg;
            irqc_pkg::CondScanMore: jump = stall || (scan_pin_reg != PinW'(PinCount - 1));
            default:                jump = 1'b1;
        endcase
        step_next = jump ? uw.target : step_reg + 1'b1;
    end

    // datapath actions
    always_comb begin
        pending_next    = pending_reg;
        in_service_next = in_service_reg;
        scan_pin_next   = scan_pin_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        vector_next     = vector_reg;
        source_next     = source_reg;
        last_next       = last_reg;
        case (uw.act)
            irqc_pkg::ActUpdate: begin
                if (cmd_reg == irqc_pkg::CmdRaise) begin
                    pending_next[pin_reg] = 1'b1;
                end else begin
                    pending_next[pin_reg] = 1'b0;
                end
                scan_pin_next = '0;
            end
            irqc_pkg::ActVisit: begin
                if (!stall) begin
                    if (hit) begin
                        m_valid_next  = 1'b1;
                        vector_next   = vector_base_reg +
                                        irqc_pkg::VectorW'(scan_pin_reg);
                        source_next   = scan_pin_reg;
                        last_next     = ~|(eligible & above);
                        pending_next[scan_pin_reg] = 1'b0;
                        if (!auto_eoi_reg) begin
                            in_service_next[scan_pin_reg] = 1'b1;
                        end
                    end
                    scan_pin_next = scan_pin_reg + 1'b1;
                end
            end
            irqc_pkg::ActClrIns: begin
                in_service_next = '0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= irqc_pkg::StepFetch;
            pending_reg     <= '0;
            in_service_reg  <= '0;
            m_valid_reg     <= 1'b0;
            irq_mask_reg    <= '0;
            auto_eoi_reg    <= 1'b0;
            vector_base_reg <= irqc_pkg::VectorBaseReset;
        end else begin
            step_reg       <= step_next;
            pending_reg    <= pending_next;
            in_service_reg <= in_service_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    irqc_pkg::RegIrqMask:    irq_mask_reg    <= cfg_wdata[PinCount-1:0];
                    irqc_pkg::RegAutoEoi:    auto_eoi_reg    <= cfg_wdata[0];
                    irqc_pkg::RegVectorBase: vector_base_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept && (uw.act == irqc_pkg::ActLatch)) begin
            cmd_reg     <= s_cmd;
            pin_reg     <= s_pin_number;
            accepts_reg <= s_cpu_accepts;
        end
        scan_pin_reg <= scan_pin_next;
        vector_reg   <= vector_next;
        source_reg   <= source_next;
        last_reg     <= last_next;
    end

endmodule
